>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tbpc_pkg.sv
// ----------------------------------------------------------------------------
// tbpc_pkg
// Types and constants of the two-button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpc_pkg;

	localparam int TIME_BITS = 48;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_HOLD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_HOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd4;

	// Register reset values, microseconds
	localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 32'd30000;
	localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 32'd3000000;
	localparam logic [CFG_W-1:0] FIRST_HOLD_RST  = 32'd3000000;
	localparam logic [CFG_W-1:0] SECOND_HOLD_RST = 32'd10000000;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 32'd2000000;

	typedef struct packed {
		logic [TIME_BITS-1:0] timestamp;
		logic                 boot_level;
		logic                 power_level;
	} in_item_t;

	typedef struct packed {
		logic boot_short;
		logic boot_hold_first;
		logic boot_hold_second;
		logic power_short;
		logic power_long;
		logic power_off_request;
	} out_item_t;

	// Per-button tracking state
	typedef struct packed {
		logic                 armed;
		logic                 pressed;
		logic                 fired;
		logic [TIME_BITS-1:0] start;
	} btn_state_t;

	// Per-button poll status
	typedef struct packed {
		logic active;
		logic starting;
		logic hold;
		logic ev_short;
	} btn_ev_t;

endpackage

`default_nettype wire

>>> rtl/core/two_button_press_classifier.sv
// ----------------------------------------------------------------------------
// two_button_press_classifier
// Short, hold and long press events of two active-low buttons from polls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one poll item: a 48-bit
//   microsecond timestamp and the boot and power pin levels (0 = pressed).
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   item per poll with the six event flags.
//   Path: a poll passes the input register, then the result register.
//   Throughput: one poll per cycle while out_ready is high; the input and
//   result registers form a two-deep pipe, and all press tracking for a poll
//   is done in the single cycle it moves from input to result register.
//   Stall: while out_ready is low the result holds; one more poll can wait in
//   the input register, after which in_ready drops.
//   Reset: both buttons disarmed, no press tracked, thresholds at their
//   defaults (30 ms debounce, 3 s short limit, 3 s and 10 s boot holds,
//   2 s power long press), both registers empty.
//   Configuration: write cfg_data to register cfg_idx when cfg_wen is high,
//   only while no poll is in flight. Indexes beyond the last are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_press_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  tbpc_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output tbpc_pkg::out_item_t                out_data,
	input  logic                               cfg_wen,
	input  logic [tbpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tbpc_pkg::CFG_W-1:0]         cfg_data
);

	localparam int PAD = tbpc_pkg::TIME_BITS - tbpc_pkg::CFG_W;

	// Configuration registers
	logic [tbpc_pkg::CFG_W-1:0] debounce_q;
	logic [tbpc_pkg::CFG_W-1:0] short_limit_q;
	logic [tbpc_pkg::CFG_W-1:0] first_hold_q;
	logic [tbpc_pkg::CFG_W-1:0] second_hold_q;
	logic [tbpc_pkg::CFG_W-1:0] long_press_q;

	// Pipe registers
	logic                 valid_s1;
	tbpc_pkg::in_item_t   item_s1;
	logic                 out_valid_q;
	tbpc_pkg::out_item_t  out_q;

	// Tracking state
	tbpc_pkg::btn_state_t boot_q;
	tbpc_pkg::btn_state_t power_q;
	logic                 first_fired_q;

	// Poll evaluation
	tbpc_pkg::btn_state_t          boot_nxt;
	tbpc_pkg::btn_state_t          power_nxt;
	tbpc_pkg::btn_ev_t             boot_ev;
	tbpc_pkg::btn_ev_t             power_ev;
	logic [tbpc_pkg::TIME_BITS-1:0] boot_len;
	logic [tbpc_pkg::TIME_BITS-1:0] power_len;
	logic                          boot_down;
	logic                          power_down;
	logic                          first_mid;
	logic                          boot_first;
	logic                          first_fired_nxt;
	tbpc_pkg::out_item_t           result;
	logic                          advance;

	// Move the input register into the result register when it is free.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign boot_down  = !item_s1.boot_level;
	assign power_down = !item_s1.power_level;

	tbpc_button u_boot (
		.cur         (boot_q),
		.down        (boot_down),
		.now         (item_s1.timestamp),
		.limit       (second_hold_q),
		.debounce    (debounce_q),
		.short_limit (short_limit_q),
		.nxt         (boot_nxt),
		.ev          (boot_ev),
		.len         (boot_len)
	);

	tbpc_button u_power (
		.cur         (power_q),
		.down        (power_down),
		.now         (item_s1.timestamp),
		.limit       (long_press_q),
		.debounce    (debounce_q),
		.short_limit (short_limit_q),
		.nxt         (power_nxt),
		.ev          (power_ev),
		.len         (power_len)
	);

	// The shared first-hold mark: boot is handled first, then power.
	// A new press on either button clears it; boot hold-first sets it.
	always_comb begin
		first_mid       = first_fired_q && !boot_ev.starting;
		boot_first      = boot_ev.active && boot_down && !first_mid &&
			(boot_len >= {{PAD{1'b0}}, first_hold_q});
		first_fired_nxt = (first_mid || boot_first) && !power_ev.starting;

		result.boot_short        = boot_ev.ev_short;
		result.boot_hold_first   = boot_first;
		result.boot_hold_second  = boot_ev.hold;
		result.power_short       = power_ev.ev_short;
		result.power_long        = power_ev.hold;
		result.power_off_request = power_ev.hold;
	end

	// Power length only enters the power compares inside its own unit.
	logic power_len_unused;
	assign power_len_unused = ^power_len;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= tbpc_pkg::DEBOUNCE_RST;
			short_limit_q <= tbpc_pkg::SHORT_LIMIT_RST;
			first_hold_q  <= tbpc_pkg::FIRST_HOLD_RST;
			second_hold_q <= tbpc_pkg::SECOND_HOLD_RST;
			long_press_q  <= tbpc_pkg::LONG_PRESS_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				tbpc_pkg::REG_DEBOUNCE:    debounce_q    <= cfg_data;
				tbpc_pkg::REG_SHORT_LIMIT: short_limit_q <= cfg_data;
				tbpc_pkg::REG_FIRST_HOLD:  first_hold_q  <= cfg_data;
				tbpc_pkg::REG_SECOND_HOLD: second_hold_q <= cfg_data;
				tbpc_pkg::REG_LONG_PRESS:  long_press_q  <= cfg_data;
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// Control and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			boot_q        <= '0;
			power_q       <= '0;
			first_fired_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q   <= 1'b1;
				boot_q        <= boot_nxt;
				power_q       <= power_nxt;
				first_fired_q <= first_fired_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tbpc_button.sv
// ----------------------------------------------------------------------------
// tbpc_button
// One poll of a single button: arming, press start, hold and short detection.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpc_button (
	input  tbpc_pkg::btn_state_t                cur,
	input  logic                                down,
	input  logic [tbpc_pkg::TIME_BITS-1:0]      now,
	input  logic [tbpc_pkg::CFG_W-1:0]          limit,
	input  logic [tbpc_pkg::CFG_W-1:0]          debounce,
	input  logic [tbpc_pkg::CFG_W-1:0]          short_limit,
	output tbpc_pkg::btn_state_t                nxt,
	output tbpc_pkg::btn_ev_t                   ev,
	output logic [tbpc_pkg::TIME_BITS-1:0]      len
);

	localparam int PAD = tbpc_pkg::TIME_BITS - tbpc_pkg::CFG_W;

	logic                            starting;
	logic                            fired_eff;
	logic [tbpc_pkg::TIME_BITS-1:0]  start_eff;

	always_comb begin
		starting  = cur.armed && down && !cur.pressed;
		start_eff = starting ? now : cur.start;
		fired_eff = cur.fired && !starting;
		// wraps modulo 2^TIME_BITS
		len = now - start_eff;

		ev.active   = cur.armed;
		ev.starting = starting;
		ev.hold     = cur.armed && down && !fired_eff &&
			(len >= {{PAD{1'b0}}, limit});
		ev.ev_short = cur.armed && !down && cur.pressed && !cur.fired &&
			(len > {{PAD{1'b0}}, debounce}) && (len < {{PAD{1'b0}}, short_limit});

		if (!cur.armed) begin
			// arm on the first released poll, nothing else
			nxt       = cur;
			nxt.armed = !down;
		end else begin
			nxt.armed   = 1'b1;
			nxt.pressed = down;
			nxt.start   = start_eff;
			nxt.fired   = fired_eff || ev.hold;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tbpc_checker.sv
// ----------------------------------------------------------------------------
// tbpc_checker
// Port-level checks of the two-button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tbpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input tbpc_pkg::in_item_t             in_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input tbpc_pkg::out_item_t            out_data,
	input logic                           cfg_wen,
	input logic [tbpc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [tbpc_pkg::CFG_W-1:0]     cfg_data
);

	logic unused_ports;
	assign unused_ports = ^{in_data, cfg_wen, cfg_idx, cfg_data};

	`ASSERT_CLK(a_off_is_long, clk, arst_n, !out_valid || (out_data.power_off_request == out_data.power_long), "power_off_request differs from power_long")
	`ASSERT_CLK(a_boot_excl, clk, arst_n, !out_valid || !(out_data.boot_short && (out_data.boot_hold_first || out_data.boot_hold_second)), "boot short together with a boot hold")
	`ASSERT_CLK(a_power_excl, clk, arst_n, !out_valid || !(out_data.power_short && out_data.power_long), "power short together with power long")
	`ASSERT_CLK(a_stall_only_full, clk, arst_n, in_ready || out_valid, "input stalled while no result waits")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind two_button_press_classifier tbpc_checker u_tbpc_checker (.*);

`default_nettype wire

>>> verif/two_button_press_classifier_test.sv
// ----------------------------------------------------------------------------
// two_button_press_classifier_test
// Self-checking bench for the two-button press classifier. It walks a short
// script of polls, then random polls over several threshold settings. Every
// result item is checked field by field against the script or the model.
// ----------------------------------------------------------------------------

module two_button_press_classifier_test;

	timeunit 1ns;
	timeprecision 1ps;

	import tbpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_POLLS    = 90;
	localparam int BACKLOG_CYCLES = 80;

	typedef enum {SET_SMALL, SET_ZERO, SET_MAX, SET_DEFAULT} thr_set_e;

	// One scripted poll; want is used only where typed is set.
	// Field order of want: boot_short, boot_hold_first, boot_hold_second,
	// power_short, power_long, power_off_request.
	typedef struct {
		in_item_t  poll;
		bit        typed;
		out_item_t want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	two_button_press_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	// Model copy of the thresholds
	logic [CFG_W-1:0] thr_debounce;
	logic [CFG_W-1:0] thr_short_limit;
	logic [CFG_W-1:0] thr_first_hold;
	logic [CFG_W-1:0] thr_second_hold;
	logic [CFG_W-1:0] thr_long_press;

	// Model copy of the press tracking; index 0 is boot, 1 is power
	logic                 armed [2];
	logic                 pressed [2];
	logic                 fired [2];
	logic [TIME_BITS-1:0] start [2];
	logic                 first_fired;

	out_item_t   events_due [$];
	script_row_t script [$];
	int          errors;
	int          results_seen;
	int          idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Classify one poll and advance the tracking state. Boot is handled
	// before power, so a power press in the same poll clears the shared
	// hold-first mark only after boot has been looked at.
	function automatic out_item_t classify_poll(in_item_t p);
		out_item_t            r;
		logic [1:0]           down;
		logic [TIME_BITS-1:0] len;
		logic [TIME_BITS-1:0] limit;
		r = '0;
		down = {~p.power_level, ~p.boot_level};
		for (int b = 0; b < 2; b++) begin
			limit = (b == 0) ? TIME_BITS'(thr_second_hold) : TIME_BITS'(thr_long_press);
			// A button is ignored until it has once been seen released
			if (!armed[b]) begin
				if (!down[b])
					armed[b] = 1'b1;
				continue;
			end
			if (down[b] && !pressed[b]) begin
				pressed[b] = 1'b1;
				start[b] = p.timestamp;
				fired[b] = 1'b0;
				first_fired = 1'b0;
			end
			// Press length wraps with the timestamp width
			len = p.timestamp - start[b];
			if (down[b] && b == 0 && !first_fired && len >= TIME_BITS'(thr_first_hold)) begin
				first_fired = 1'b1;
				r.boot_hold_first = 1'b1;
			end
			if (down[b] && !fired[b] && len >= limit) begin
				fired[b] = 1'b1;
				if (b == 0) begin
					r.boot_hold_second = 1'b1;
				end else begin
					r.power_long = 1'b1;
					r.power_off_request = 1'b1;
				end
			end
			if (!down[b] && pressed[b]) begin
				if (!fired[b] && len > TIME_BITS'(thr_debounce)
						&& len < TIME_BITS'(thr_short_limit)) begin
					if (b == 0)
						r.boot_short = 1'b1;
					else
						r.power_short = 1'b1;
				end
				pressed[b] = 1'b0;
			end
		end
		return r;
	endfunction

	// Mostly back to back, sometimes a short gap, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic longint unsigned rand_upto(longint unsigned n);
		longint unsigned r;
		r = {$urandom(), $urandom()};
		return r % (n + 1);
	endfunction

	function automatic void add_row(logic [TIME_BITS-1:0] ts, logic boot, logic power,
			bit typed, out_item_t want);
		script_row_t row;
		row.poll.timestamp = ts;
		row.poll.boot_level = boot;
		row.poll.power_level = power;
		row.typed = typed;
		row.want = want;
		script.push_back(row);
	endfunction

	// Offer one poll, hold it until taken, then queue its expected result.
	task automatic send_poll(in_item_t p, bit typed, out_item_t want);
		out_item_t model;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		model = classify_poll(p);
		events_due.push_back(typed ? want : model);
	endtask

	task automatic rest_input(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every expected result is out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_DEBOUNCE:    thr_debounce = val;
			REG_SHORT_LIMIT: thr_short_limit = val;
			REG_FIRST_HOLD:  thr_first_hold = val;
			REG_SECOND_HOLD: thr_second_hold = val;
			REG_LONG_PRESS:  thr_long_press = val;
			default: ;
		endcase
	endtask

	task automatic note_mismatch(string field, logic want, logic got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("result %0d %s: expected %0b got %0b", results_seen, field, want, got);
	endtask

	// Result check: pop the oldest expectation for every item taken
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (events_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result %0d unexpected: got %b", results_seen, out_data);
			end else begin
				want = events_due.pop_front();
				if (out_data.boot_short !== want.boot_short)
					note_mismatch("boot_short", want.boot_short, out_data.boot_short);
				if (out_data.boot_hold_first !== want.boot_hold_first)
					note_mismatch("boot_hold_first", want.boot_hold_first,
						out_data.boot_hold_first);
				if (out_data.boot_hold_second !== want.boot_hold_second)
					note_mismatch("boot_hold_second", want.boot_hold_second,
						out_data.boot_hold_second);
				if (out_data.power_short !== want.power_short)
					note_mismatch("power_short", want.power_short, out_data.power_short);
				if (out_data.power_long !== want.power_long)
					note_mismatch("power_long", want.power_long, out_data.power_long);
				if (out_data.power_off_request !== want.power_off_request)
					note_mismatch("power_off_request", want.power_off_request,
						out_data.power_off_request);
			end
			results_seen++;
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result side: random stalls, calm windows, and one long hold-off that
	// fills the pipe so the input side has to stall.
	initial begin : receiver
		int gap;
		int tick;
		bit rx_calm;
		bit backlog_done;
		out_ready = 1'b0;
		tick = 0;
		rx_calm = 1'b0;
		backlog_done = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (tick % 128 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (!backlog_done && results_seen >= 150) begin
				backlog_done = 1'b1;
				out_ready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(negedge clk);
			end else begin
				gap = rx_calm ? 0 : pick_gap();
				if (gap == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		thr_set_e             plan [8];
		logic [CFG_W-1:0]     thr [5];
		in_item_t             p;
		logic [TIME_BITS-1:0] ts_now;
		logic [63:0]          rnd;
		longint unsigned      scale;
		logic                 b_lvl;
		logic                 p_lvl;
		bit                   tx_calm;
		int                   r;

		plan = '{SET_SMALL, SET_ZERO, SET_SMALL, SET_MAX,
			SET_SMALL, SET_DEFAULT, SET_SMALL, SET_SMALL};
		errors = 0;
		results_seen = 0;
		idle_cycles = 0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;

		// Model state after reset
		thr_debounce = DEBOUNCE_RST;
		thr_short_limit = SHORT_LIMIT_RST;
		thr_first_hold = FIRST_HOLD_RST;
		thr_second_hold = SECOND_HOLD_RST;
		thr_long_press = LONG_PRESS_RST;
		for (int b = 0; b < 2; b++) begin
			armed[b] = 1'b0;
			pressed[b] = 1'b0;
			fired[b] = 1'b0;
			start[b] = '0;
		end
		first_fired = 1'b0;

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Script at the reset thresholds (microseconds)
		// both held out of reset: not armed, nothing happens
		add_row(48'd0, 1'b0, 1'b0, 1, 6'b000000);
		// first release arms both buttons
		add_row(48'd5, 1'b1, 1'b1, 1, 6'b000000);
		// boot press exactly debounce long: no short
		add_row(48'd100, 1'b0, 1'b1, 0, '0);
		add_row(48'd30100, 1'b1, 1'b1, 0, '0);
		// boot press of 50 ms: short
		add_row(48'd40000, 1'b0, 1'b1, 0, '0);
		add_row(48'd90000, 1'b1, 1'b1, 1, 6'b100000);
		// power held to the long time: long plus power-off, then no repeat
		add_row(48'd100000, 1'b1, 1'b0, 0, '0);
		add_row(48'd2100000, 1'b1, 1'b0, 1, 6'b000011);
		add_row(48'd2100001, 1'b1, 1'b0, 0, '0);
		add_row(48'd2200000, 1'b1, 1'b1, 0, '0);
		// boot held through both hold times
		add_row(48'd3000000, 1'b0, 1'b1, 0, '0);
		add_row(48'd6000000, 1'b0, 1'b1, 0, '0);
		add_row(48'd13000000, 1'b0, 1'b1, 0, '0);
		// power press clears the shared mark after boot is looked at: no new hold-first
		add_row(48'd13000100, 1'b0, 1'b0, 0, '0);
		add_row(48'd13100000, 1'b1, 1'b1, 0, '0);
		// press across the timestamp wrap
		add_row('1, 1'b0, 1'b1, 0, '0);
		add_row(48'd49999, 1'b1, 1'b1, 0, '0);
		// timestamp going backwards reads as a very long press
		add_row(48'd60000, 1'b0, 1'b1, 0, '0);
		add_row(48'd59000, 1'b0, 1'b1, 0, '0);
		add_row(48'd70000, 1'b1, 1'b1, 0, '0);
		// both released at exactly the short limit: no short
		add_row(48'd80000, 1'b0, 1'b0, 0, '0);
		add_row(48'd3080000, 1'b1, 1'b1, 0, '0);

		foreach (script[i]) begin
			send_poll(script[i].poll, script[i].typed, script[i].want);
			rest_input(pick_gap());
		end

		ts_now = 48'd3100000;
		b_lvl = 1'b1;
		p_lvl = 1'b1;
		foreach (plan[ph]) begin
			drain();
			for (int i = 0; i < 5; i++) begin
				case (plan[ph])
					SET_ZERO:    thr[i] = '0;
					SET_MAX:     thr[i] = '1;
					SET_DEFAULT: thr[i] = '0;
					default:     thr[i] = ($urandom_range(0, 7) == 0) ? '0
						: CFG_W'($urandom_range(1, 500));
				endcase
			end
			if (plan[ph] == SET_DEFAULT)
				thr = '{DEBOUNCE_RST, SHORT_LIMIT_RST, FIRST_HOLD_RST,
					SECOND_HOLD_RST, LONG_PRESS_RST};
			set_reg(REG_DEBOUNCE, thr[0]);
			set_reg(REG_SHORT_LIMIT, thr[1]);
			set_reg(REG_FIRST_HOLD, thr[2]);
			set_reg(REG_SECOND_HOLD, thr[3]);
			set_reg(REG_LONG_PRESS, thr[4]);
			// an index past the last register must change nothing
			set_reg(CFG_IDX_W'($urandom_range(REG_LONG_PRESS + 1, (1 << CFG_IDX_W) - 1)),
				$urandom());
			@(negedge clk);
			cfg_wen <= 1'b0;

			// scale time steps to the largest threshold in force
			scale = 8;
			foreach (thr[i])
				if (thr[i] > scale)
					scale = thr[i];
			tx_calm = ($urandom_range(0, 2) == 0);

			for (int n = 0; n < PHASE_POLLS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					// jump anywhere, across the wrap too
					rnd = {$urandom(), $urandom()};
					ts_now = rnd[TIME_BITS-1:0];
				end else if (r < 7) begin
					ts_now = ts_now - $urandom_range(1, 50);
				end else if (r < 15) begin
					ts_now = ts_now;
				end else if (r < 70) begin
					ts_now = ts_now + TIME_BITS'(rand_upto(scale / 4));
				end else begin
					ts_now = ts_now + TIME_BITS'(rand_upto(scale * 2 + 2));
				end
				// levels mostly stay put, so presses span several polls
				if ($urandom_range(0, 3) == 0)
					b_lvl = ~b_lvl;
				if ($urandom_range(0, 3) == 0)
					p_lvl = ~p_lvl;
				p.timestamp = ts_now;
				p.boot_level = b_lvl;
				p.power_level = p_lvl;
				send_poll(p, 0, '0);
				rest_input(tx_calm ? 0 : pick_gap());
			end
		end

		drain();
		// let any stray result show up before the verdict
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
